### sv/one_wire_bus_master_assert.svh
// assertion macros for the one-wire bus master
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, switched off while reset is high
`define OWM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("one-wire master assertion failed");
// checked property that also holds through reset
`define OWM_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("one-wire master assertion failed");
`else
`define OWM_ASSERT(name, clk, rst, prop)
`define OWM_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### sv/owm_pkg.sv
// types and constants shared by the one-wire bus master files
`timescale 1ns / 1ps
package owm_pkg;

   localparam int BITS_PER_BYTE    = 8;
   localparam int CNT_W            = 11;
   localparam int BIT_IDX_W        = $clog2(BITS_PER_BYTE + 1);
   localparam int PRESENCE_LOW_MAX = 240;
   localparam int CSR_ADDR_W       = 5;
   localparam int CSR_DATA_W       = 32;

   localparam logic [10:0] RESET_LOW_DEF     = 11'd750;
   localparam logic [7:0]  RESET_RELEASE_DEF = 8'd15;
   localparam logic [9:0]  PRESENCE_WAIT_DEF = 10'd200;
   localparam logic [7:0]  PRESENCE_LIM_DEF  = 8'd120;
   localparam logic [7:0]  LONG_SLOT_DEF     = 8'd60;
   localparam logic [5:0]  SHORT_PULSE_DEF   = 6'd2;
   localparam logic [5:0]  SAMPLE_DELAY_DEF  = 6'd12;
   localparam logic [7:0]  READ_RECOV_DEF    = 8'd50;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_RESET_LOW     = 3'd0,
      REG_RESET_RELEASE = 3'd1,
      REG_PRESENCE_WAIT = 3'd2,
      REG_PRESENCE_LIM  = 3'd3,
      REG_LONG_SLOT     = 3'd4,
      REG_SHORT_PULSE   = 3'd5,
      REG_SAMPLE_DELAY  = 3'd6,
      REG_READ_RECOV    = 3'd7
   } reg_idx_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_LOW   = 4'd1,
      PH_RST_REL   = 4'd2,
      PH_PRES_WAIT = 4'd3,
      PH_PRES_LOW  = 4'd4,
      PH_WR_LOW    = 4'd5,
      PH_WR_HIGH   = 4'd6,
      PH_RD_LOW    = 4'd7,
      PH_RD_WAIT   = 4'd8,
      PH_RD_SAMPLE = 4'd9,
      PH_RD_RECOV  = 4'd10
   } phase_type;

   typedef logic [CNT_W:0] cnt_ext_type;

   typedef struct packed {
      logic [10:0] reset_low_ticks;
      logic [7:0]  reset_release_ticks;
      logic [9:0]  presence_wait_ticks;
      logic [7:0]  presence_low_limit;
      logic [7:0]  long_slot_ticks;
      logic [5:0]  short_pulse_ticks;
      logic [5:0]  sample_delay_ticks;
      logic [7:0]  read_recovery_ticks;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  data_byte;
      logic        line_level;
   } item_type;

   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        presence_failed;
      logic [7:0]  read_value;
   } res_type;

endpackage

### sv/owm_req_if.sv
// command channel: one word per microsecond tick
`timescale 1ns / 1ps
interface owm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;
   logic       line_level;

   modport source (output valid, output command, output data_byte, output line_level,
                   input ready);
   modport sink (input valid, input command, input data_byte, input line_level,
                 output ready);
endinterface

### sv/owm_rsp_if.sv
// result channel: bus drive and status, one word per tick
`timescale 1ns / 1ps
interface owm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       presence_failed;
   logic [7:0] read_value;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence_failed, output read_value, input ready);
   modport sink (input valid, input drive_low, input busy_res, input done_res,
                 input presence_failed, input read_value, output ready);
endinterface

### sv/owm_csr.sv
// apb timing register file
`timescale 1ns / 1ps
module owm_csr
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_RESET_LOW:     cfg_in.reset_low_ticks     = pwdata[10:0];
            REG_RESET_RELEASE: cfg_in.reset_release_ticks = pwdata[7:0];
            REG_PRESENCE_WAIT: cfg_in.presence_wait_ticks = pwdata[9:0];
            REG_PRESENCE_LIM:  cfg_in.presence_low_limit  = pwdata[7:0];
            REG_LONG_SLOT:     cfg_in.long_slot_ticks     = pwdata[7:0];
            REG_SHORT_PULSE:   cfg_in.short_pulse_ticks   = pwdata[5:0];
            REG_SAMPLE_DELAY:  cfg_in.sample_delay_ticks  = pwdata[5:0];
            REG_READ_RECOV:    cfg_in.read_recovery_ticks = pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_RESET_LOW:     prdata = CSR_DATA_W'(cfg_ff.reset_low_ticks);
         REG_RESET_RELEASE: prdata = CSR_DATA_W'(cfg_ff.reset_release_ticks);
         REG_PRESENCE_WAIT: prdata = CSR_DATA_W'(cfg_ff.presence_wait_ticks);
         REG_PRESENCE_LIM:  prdata = CSR_DATA_W'(cfg_ff.presence_low_limit);
         REG_LONG_SLOT:     prdata = CSR_DATA_W'(cfg_ff.long_slot_ticks);
         REG_SHORT_PULSE:   prdata = CSR_DATA_W'(cfg_ff.short_pulse_ticks);
         REG_SAMPLE_DELAY:  prdata = CSR_DATA_W'(cfg_ff.sample_delay_ticks);
         REG_READ_RECOV:    prdata = CSR_DATA_W'(cfg_ff.read_recovery_ticks);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RESET_LOW_DEF;
         cfg_ff.reset_release_ticks <= RESET_RELEASE_DEF;
         cfg_ff.presence_wait_ticks <= PRESENCE_WAIT_DEF;
         cfg_ff.presence_low_limit  <= PRESENCE_LIM_DEF;
         cfg_ff.long_slot_ticks     <= LONG_SLOT_DEF;
         cfg_ff.short_pulse_ticks   <= SHORT_PULSE_DEF;
         cfg_ff.sample_delay_ticks  <= SAMPLE_DELAY_DEF;
         cfg_ff.read_recovery_ticks <= READ_RECOV_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/owm_fsm.sv
// bus sequencer: one tick of the reset, write and read slot timing per step
`timescale 1ns / 1ps
module owm_fsm
   import owm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  item_type item,
   input  cfg_type  cfg,
   output res_type  res
);

   phase_type              phase_ff, phase_in;
   logic [CNT_W-1:0]       tick_ff, tick_in;
   logic [7:0]             shift_ff, shift_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic                   pres_ff, pres_in;
   logic [7:0]             last_ff, last_in;

   phase_type              ph;
   logic [CNT_W-1:0]       tick;
   logic [7:0]             shift;
   logic [BIT_IDX_W-1:0]   bidx;
   logic [BIT_IDX_W-1:0]   bidx_inc;
   cnt_ext_type            tick_inc;
   logic [7:0]             dur;
   logic [7:0]             sampled;
   logic [7:0]             short_ext;

   assign short_ext = 8'(cfg.short_pulse_ticks);
   assign sampled   = {item.line_level, shift[7:1]};

   always_comb begin
      // a command on an idle tick makes that tick its first one
      ph    = phase_ff;
      tick  = tick_ff;
      shift = shift_ff;
      bidx  = bit_ff;
      if (phase_ff == PH_IDLE && item.command != CMD_TICK) begin
         tick = '0;
         bidx = '0;
         case (item.command)
            CMD_RESET: ph = PH_RST_LOW;
            CMD_WRITE: begin
               shift = item.data_byte;
               ph    = PH_WR_LOW;
            end
            default: begin
               shift = '0;
               ph    = PH_RD_LOW;
            end
         endcase
      end
   end

   assign tick_inc = cnt_ext_type'(tick) + cnt_ext_type'(1);
   assign bidx_inc = bidx + BIT_IDX_W'(1);

   always_comb begin
      phase_in      = ph;
      tick_in       = tick;
      shift_in      = shift;
      bit_in        = bidx;
      pres_in       = pres_ff;
      last_in       = last_ff;
      dur           = '0;
      res.drive_low = 1'b0;
      res.busy_res  = 1'b1;
      res.done_res  = 1'b0;
      unique case (ph)
         PH_IDLE: begin
            res.busy_res = 1'b0;
         end
         PH_RST_LOW: begin
            res.drive_low = 1'b1;
            tick_in       = tick_inc[CNT_W-1:0];
            if (tick_inc >= cnt_ext_type'(cfg.reset_low_ticks)) begin
               tick_in  = '0;
               phase_in = (cfg.reset_release_ticks == '0) ? PH_PRES_WAIT : PH_RST_REL;
            end
         end
         PH_RST_REL: begin
            tick_in = tick_inc[CNT_W-1:0];
            if (tick_inc >= cnt_ext_type'(cfg.reset_release_ticks)) begin
               tick_in  = '0;
               phase_in = PH_PRES_WAIT;
            end
         end
         PH_PRES_WAIT: begin
            if (item.line_level) begin
               tick_in = tick_inc[CNT_W-1:0];
               if (tick_inc >= cnt_ext_type'(cfg.presence_wait_ticks)) begin
                  pres_in      = 1'b1;
                  phase_in     = PH_IDLE;
                  tick_in      = '0;
                  res.done_res = 1'b1;
               end
            end else begin
               // first low tick already counts
               tick_in  = CNT_W'(1);
               phase_in = PH_PRES_LOW;
            end
         end
         PH_PRES_LOW: begin
            if (item.line_level) begin
               pres_in      = (cnt_ext_type'(tick) >= cnt_ext_type'(cfg.presence_low_limit));
               phase_in     = PH_IDLE;
               tick_in      = '0;
               res.done_res = 1'b1;
            end else begin
               tick_in = tick_inc[CNT_W-1:0];
               if (tick_inc >= cnt_ext_type'(PRESENCE_LOW_MAX)) begin
                  pres_in      = (tick_inc >= cnt_ext_type'(cfg.presence_low_limit));
                  phase_in     = PH_IDLE;
                  tick_in      = '0;
                  res.done_res = 1'b1;
               end
            end
         end
         PH_WR_LOW: begin
            res.drive_low = 1'b1;
            tick_in       = tick_inc[CNT_W-1:0];
            dur           = shift[0] ? short_ext : cfg.long_slot_ticks;
            if (tick_inc >= cnt_ext_type'(dur)) begin
               tick_in  = '0;
               phase_in = PH_WR_HIGH;
            end
         end
         PH_WR_HIGH: begin
            tick_in = tick_inc[CNT_W-1:0];
            dur     = shift[0] ? cfg.long_slot_ticks : short_ext;
            if (tick_inc >= cnt_ext_type'(dur)) begin
               shift_in = {1'b0, shift[7:1]};
               bit_in   = bidx_inc;
               tick_in  = '0;
               if (bidx_inc >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
               end else begin
                  phase_in = PH_WR_LOW;
               end
            end
         end
         PH_RD_LOW: begin
            res.drive_low = 1'b1;
            tick_in       = tick_inc[CNT_W-1:0];
            if (tick_inc >= cnt_ext_type'(cfg.short_pulse_ticks)) begin
               tick_in  = '0;
               phase_in = (cfg.sample_delay_ticks == '0) ? PH_RD_SAMPLE : PH_RD_WAIT;
            end
         end
         PH_RD_WAIT: begin
            tick_in = tick_inc[CNT_W-1:0];
            if (tick_inc >= cnt_ext_type'(cfg.sample_delay_ticks)) begin
               tick_in  = '0;
               phase_in = PH_RD_SAMPLE;
            end
         end
         PH_RD_SAMPLE: begin
            shift_in = sampled;
            tick_in  = '0;
            if (cfg.read_recovery_ticks == '0) begin
               bit_in = bidx_inc;
               if (bidx_inc >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                  last_in      = sampled;
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
               end else begin
                  phase_in = PH_RD_LOW;
               end
            end else begin
               phase_in = PH_RD_RECOV;
            end
         end
         PH_RD_RECOV: begin
            tick_in = tick_inc[CNT_W-1:0];
            if (tick_inc >= cnt_ext_type'(cfg.read_recovery_ticks)) begin
               tick_in = '0;
               bit_in  = bidx_inc;
               if (bidx_inc >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                  last_in      = shift;
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
               end else begin
                  phase_in = PH_RD_LOW;
               end
            end
         end
         default: begin
            phase_in     = PH_IDLE;
            tick_in      = '0;
            res.busy_res = 1'b0;
         end
      endcase
      res.presence_failed = pres_in;
      res.read_value      = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         shift_ff <= '0;
         bit_ff   <= '0;
         pres_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         pres_ff  <= pres_in;
         last_ff  <= last_in;
      end
   end

endmodule

### sv/one_wire_bus_master.sv
// one-wire bus master: top level with input and result registers
//
// req_ch carries one word per microsecond tick: a command (tick, reset and
// presence check, write byte, read byte), the byte to write and the sampled
// bus level. rsp_ch returns one word per request word: drive_low for the bus
// pad, busy, done on the finishing tick, the last presence result and the
// last byte read. A command is taken only while idle and is ignored otherwise.
// Timing registers sit on the apb port at byte address 4*index and may be
// written only while no command is running.
// A word accepted into the input register passes through the sequencer into the
// result register once that register is free or being emptied. Throughput: one
// word per cycle while rsp_ch does not stall, set by the single sequencer step
// between the input register and the result register.
// Reset (synchronous, active high) clears the valid flags of both registers, idles the sequencer
// and restores the default timing values.
// While rsp_ch is stalled the result word holds and one more word is taken
// into the input register; after that req_ch.ready drops until a result moves.
`timescale 1ns / 1ps
`include "one_wire_bus_master_assert.svh"
module one_wire_bus_master
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   owm_req_if.sink               req_ch,
   owm_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type  cfg;
   res_type  res;
   item_type in_item_ff;
   logic     in_vld_ff;
   logic     in_vld_in;
   res_type  rsp_res_ff;
   logic     rsp_vld_ff;
   logic     rsp_vld_in;
   logic     advance;
   logic     step;

   owm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   owm_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   // result register free or being emptied this cycle
   assign advance      = !rsp_vld_ff || rsp_ch.ready;
   assign step         = in_vld_ff && advance;
   assign req_ch.ready = !in_vld_ff || advance;
   assign in_vld_in    = req_ch.ready ? req_ch.valid : in_vld_ff;
   assign rsp_vld_in   = advance ? in_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.command    <= cmd_type'(req_ch.command);
         in_item_ff.data_byte  <= req_ch.data_byte;
         in_item_ff.line_level <= req_ch.line_level;
      end
      if (step) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.drive_low       = rsp_res_ff.drive_low;
   assign rsp_ch.busy_res        = rsp_res_ff.busy_res;
   assign rsp_ch.done_res        = rsp_res_ff.done_res;
   assign rsp_ch.presence_failed = rsp_res_ff.presence_failed;
   assign rsp_ch.read_value      = rsp_res_ff.read_value;

   `OWM_ASSERT(a_done_in_command, clock, reset, rsp_vld_ff && rsp_res_ff.done_res |-> rsp_res_ff.busy_res)
   `OWM_ASSERT(a_drive_in_command, clock, reset, rsp_vld_ff && rsp_res_ff.drive_low |-> rsp_res_ff.busy_res)
   `OWM_ASSERT(a_held_word_kept, clock, reset, in_vld_ff && !advance |=> in_vld_ff && rsp_vld_ff)
   `OWM_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_vld_ff && !in_vld_ff)

endmodule
